// ===== rtl/core/sqlf_pkg.sv =====
// Package with the shared types and codes of the store queue forwarding core.
package sqlf_pkg;

    localparam int unsigned AddrW = 48;
    localparam int unsigned DataW = 64;
    localparam int unsigned DwW   = 45;

    typedef enum logic [2:0] {
        FN_PUSH   = 3'd0,
        FN_FILL   = 3'd1,
        FN_ANNUL  = 3'd2,
        FN_RETIRE = 3'd3,
        FN_SNOOP  = 3'd4,
        FN_MERGE  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOMATCH  = 3'd1,
        ST_FORWARD  = 3'd2,
        ST_NOTREADY = 3'd3,
        ST_PARTIAL  = 3'd4,
        ST_FULL     = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_BAD      = 3'd7
    } t_status;

    // Mask of the low bytes of a value of the given size.
    function automatic logic [63:0] size_mask(input logic [1:0] sz);
        logic [63:0] m;
        case (sz)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Bit position of an access inside the big-endian doubleword.
    function automatic logic [5:0] lane_shift(input logic [2:0] off, input logic [1:0] sz);
        logic [3:0] nb;
        logic [3:0] sh;
        nb = 4'd1 << sz;
        sh = 4'd8 - nb - {1'b0, off};
        return {sh[2:0], 3'b000};
    endfunction

    function automatic logic crosses(input logic [2:0] off, input logic [1:0] sz);
        logic [4:0] tot;
        tot = {2'b00, off} + (5'd1 << sz);
        return tot > 5'd8;
    endfunction

    // Byte mask (one bit per byte) of an access.
    function automatic logic [7:0] lane_bytes(input logic [2:0] off, input logic [1:0] sz);
        logic [7:0] m;
        logic [5:0] sh;
        sh = lane_shift(off, sz);
        m = ((8'd1 << (4'd1 << sz)) - 8'd1);
        if (sz == 2'd3) begin
            m = 8'hFF;
        end
        return m << sh[5:3];
    endfunction

    function automatic logic [63:0] byte_swap(input logic [63:0] v, input logic [1:0] sz);
        logic [63:0] r;
        r = '0;
        case (sz)
            2'd0: r = {56'd0, v[7:0]};
            2'd1: r = {48'd0, v[7:0], v[15:8]};
            2'd2: r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
            default: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                          v[39:32], v[47:40], v[55:48], v[63:56]};
        endcase
        return r;
    endfunction

    function automatic logic [63:0] expand(input logic [7:0] b);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = {8{b[i]}};
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/store_queue_load_forwarding_core.sv =====
// Top level of the store queue with store-to-load forwarding.
//
// One input channel (i_valid / o_stall) carries a transaction with an
// operation code: push a store, fill a store value, annul a store, retire
// the oldest store, snoop a load or merge a load. Every transaction gives
// exactly one result transaction on the output channel (o_valid / i_stall)
// with a status, a data word and a slot number.
// Push and retire pass S_EXEC and S_OUT between acceptance and a valid result.
// Fill and annul also pass S_CMP, since they read the entry before writing it back.
// Snoop and merge walk the live queue entries one per cycle through a single
// compare-and-align unit that reads the entry memory at one address.
// The block works on one transaction at a time: o_stall stays high from
// acceptance until the result has been taken.
// When the receiver holds i_stall high the result register keeps its
// contents and no new transaction is accepted.
// Reset empties the queue (head and count go to zero); the entry memory is
// not cleared since only live entries are read.
module store_queue_load_forwarding_core #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_func,
    input  logic [47:0]           i_address,
    input  logic [1:0]            i_size_code,
    input  logic [63:0]           i_data,
    input  logic                  i_data_known,
    input  logic                  i_inverse_endian,
    input  logic                  i_quad_access,
    input  logic [3:0]            i_slot,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic [63:0]           o_result_data,
    output logic [3:0]            o_result_slot
);
    import sqlf_pkg::*;

    localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_WALK = 5'b00100,
        S_CMP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Entry memory: one write port, one registered read port.
    typedef struct packed {
        logic [DwW-1:0] dw;
        logic [2:0]     off;
        logic [1:0]     sz;
        logic [63:0]    value;
        logic           known;
        logic           inv;
        logic           annul;
    } t_entry;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [IdxW-1:0] r_head, n_head;
    logic [CntW-1:0] r_count, n_count;

    // Captured transaction.
    logic [2:0]     r_func;
    logic [DwW-1:0] r_dw;
    logic [2:0]     r_off;
    logic [1:0]     r_sz;
    logic [63:0]    r_data;
    logic           r_known, r_inv, r_quad;
    logic [3:0]     r_slot;

    // Walk position (number of entries from head) and accumulator.
    logic [CntW-1:0] r_k, n_k;
    logic [63:0]     r_acc, n_acc;
    logic            r_rd_pend, n_rd_pend;
    logic [IdxW-1:0] r_rd_slot, n_rd_slot;

    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_status, n_status;
    logic [63:0]   r_rdata, n_rdata;
    logic [3:0]    r_rslot, n_rslot;

    logic          we;
    logic [IdxW-1:0] waddr;
    t_entry        wdata;
    logic          re;
    logic [IdxW-1:0] raddr;

    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    // Slot of the k-th entry from head, modulo the depth.
    function automatic logic [IdxW-1:0] slot_at(input logic [IdxW-1:0] h,
                                                 input logic [CntW-1:0] k);
        logic [CntW:0] s;
        s = {{(CntW-IdxW+1){1'b0}}, h} + {1'b0, k};
        if (s >= (CntW+1)'(QUEUE_DEPTH)) begin
            s = s - (CntW+1)'(QUEUE_DEPTH);
        end
        return s[IdxW-1:0];
    endfunction

    // Compare-and-align unit working on the entry just read.
    logic [7:0]  need_b, have_b, hit_b;
    logic [63:0] st_al, need_m, have_m;
    logic        same_dw, usable;
    logic [5:0]  ld_sh;
    logic [63:0] sv;

    always_comb begin
        need_b  = lane_bytes(r_off, r_sz);
        have_b  = lane_bytes(r_rd.off, r_rd.sz);
        hit_b   = need_b & have_b;
        need_m  = expand(need_b);
        have_m  = expand(have_b);
        ld_sh   = lane_shift(r_off, r_sz);
        same_dw = (r_rd.dw == r_dw) && !r_rd.annul;
        usable  = same_dw && (hit_b != 8'd0);
        sv      = (r_rd.inv != r_inv) ? byte_swap(r_rd.value, r_rd.sz) : r_rd.value;
        st_al   = (sv & size_mask(r_rd.sz)) << lane_shift(r_rd.off, r_rd.sz);
    end

    // Live test for fill and annul.
    logic [IdxW:0] rel;
    logic          slot_live;
    always_comb begin
        rel = {1'b0, r_slot[IdxW-1:0]} + (IdxW+1)'(QUEUE_DEPTH) - {1'b0, r_head};
        if (rel >= (IdxW+1)'(QUEUE_DEPTH)) begin
            rel = rel - (IdxW+1)'(QUEUE_DEPTH);
        end
        slot_live = ({28'd0, r_slot} < 32'(QUEUE_DEPTH)) &&
                    ({{(31-IdxW){1'b0}}, rel} < {{(32-CntW){1'b0}}, r_count});
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_k       = r_k;
        n_acc     = r_acc;
        n_rd_pend = 1'b0;
        n_rd_slot = r_rd_slot;
        n_ovalid  = r_ovalid;
        n_status  = r_status;
        n_rdata   = r_rdata;
        n_rslot   = r_rslot;
        we        = 1'b0;
        waddr     = r_slot[IdxW-1:0];
        wdata     = r_rd;
        re        = 1'b0;
        raddr     = slot_at(r_head, r_k);

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_BAD;
                n_rdata  = '0;
                n_rslot  = '0;
                n_state  = S_OUT;
                case (r_func)
                    FN_PUSH: begin
                        if (crosses(r_off, r_sz)) begin
                            n_status = ST_BAD;
                        end else if (r_count >= CntW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            we          = 1'b1;
                            waddr       = slot_at(r_head, r_count);
                            wdata.dw    = r_dw;
                            wdata.off   = r_off;
                            wdata.sz    = r_sz;
                            wdata.value = r_known ? (r_data & size_mask(r_sz)) : '0;
                            wdata.known = r_known;
                            wdata.inv   = r_inv;
                            wdata.annul = 1'b0;
                            n_count     = r_count + 1'b1;
                            n_status    = ST_OK;
                            n_rslot     = 4'(waddr);
                        end
                    end
                    FN_FILL, FN_ANNUL: begin
                        // Read the target first; the update happens in S_CMP.
                        if (slot_live) begin
                            re      = 1'b1;
                            raddr   = r_slot[IdxW-1:0];
                            n_state = S_CMP;
                        end
                    end
                    FN_RETIRE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_rslot  = 4'(r_head);
                            n_head   = slot_at(r_head, CntW'(1));
                            n_count  = r_count - 1'b1;
                            n_status = ST_OK;
                        end
                    end
                    FN_SNOOP: begin
                        if (!crosses(r_off, r_sz)) begin
                            n_status = ST_NOMATCH;
                            n_k      = r_count;
                            n_state  = S_WALK;
                        end
                    end
                    FN_MERGE: begin
                        if (!crosses(r_off, r_sz)) begin
                            n_status = ST_OK;
                            n_acc    = (r_data & size_mask(r_sz)) << ld_sh;
                            n_k      = '0;
                            n_state  = S_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                // Evaluate the entry read last cycle, then issue the next read.
                if (r_rd_pend) begin
                    if (r_func == FN_SNOOP) begin
                        if (usable) begin
                            n_rslot = 4'(r_rd_slot);
                            if (r_quad || hit_b != need_b) begin
                                n_status = ST_PARTIAL;
                            end else if (!r_rd.known) begin
                                n_status = ST_NOTREADY;
                            end else begin
                                n_status = ST_FORWARD;
                                n_rdata  = (st_al & need_m) >> ld_sh;
                            end
                            n_state = S_OUT;
                        end
                    end else if (usable && r_rd.known) begin
                        n_acc = (r_acc & ~have_m) | (st_al & have_m);
                    end
                end
                if (n_state == S_WALK) begin
                    if (r_func == FN_SNOOP) begin
                        if (r_k == '0) begin
                            n_state = S_OUT;
                        end else begin
                            re        = 1'b1;
                            raddr     = slot_at(r_head, r_k - 1'b1);
                            n_k       = r_k - 1'b1;
                            n_rd_pend = 1'b1;
                            n_rd_slot = raddr;
                        end
                    end else begin
                        if (r_k == r_count) begin
                            if (!r_rd_pend) begin
                                n_rdata = (n_acc & need_m) >> ld_sh;
                                n_state = S_OUT;
                            end
                        end else begin
                            re        = 1'b1;
                            raddr     = slot_at(r_head, r_k);
                            n_k       = r_k + 1'b1;
                            n_rd_pend = 1'b1;
                            n_rd_slot = raddr;
                        end
                    end
                end
            end
            S_CMP: begin
                we    = 1'b1;
                waddr = r_slot[IdxW-1:0];
                wdata = r_rd;
                if (r_func == FN_FILL) begin
                    wdata.value = r_data & size_mask(r_rd.sz);
                    wdata.known = 1'b1;
                end else begin
                    wdata.annul = 1'b1;
                end
                n_status = ST_OK;
                n_rslot  = r_slot;
                n_state  = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_ovalid  <= n_ovalid;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_dw    <= i_address[AddrW-1:3];
            r_off   <= i_address[2:0];
            r_sz    <= i_size_code;
            r_data  <= i_data;
            r_known <= i_data_known;
            r_inv   <= i_inverse_endian;
            r_quad  <= i_quad_access;
            r_slot  <= i_slot;
        end
        r_k       <= n_k;
        r_acc     <= n_acc;
        r_rd_slot <= n_rd_slot;
        r_status  <= n_status;
        r_rdata   <= n_rdata;
        r_rslot   <= n_rslot;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_result_data = r_rdata;
    assign o_result_slot = r_rslot;

endmodule

// ===== rtl/core/sqlf_checker.sv =====
// Port-level checker for the store queue forwarding core, with its bind.
module sqlf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [63:0] o_result_data,
    input logic [3:0]  o_result_slot
);
    import sqlf_pkg::*;

    // A result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_data) && $stable(o_status))
        else $error("result changed under stall");

    // No transaction is taken while a result is still waiting.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("ready while result pending");

    // An accepted transaction cannot produce its result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result too early");

    // Only forwarded or merged results carry data.
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FORWARD && o_status != ST_OK |-> o_result_data == 64'd0)
        else $error("data on a non-data status");

    // Results that name no store carry slot zero.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOMATCH || o_status == ST_FULL ||
                    o_status == ST_EMPTY || o_status == ST_BAD) |-> o_result_slot == 4'd0)
        else $error("slot on a result without a store");

endmodule

bind store_queue_load_forwarding_core sqlf_checker u_sqlf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_result_data(o_result_data), .o_result_slot(o_result_slot)
);
